[sv/b64d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, status codes and the character map of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned MAX_RES = 3;
    localparam logic [2:0] PAD_SAT = 3'd4;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CHAR    = 2'd1,
        ST_BAD_LEN     = 2'd2,
        ST_PAD_OVERRUN = 2'd3
    } status_t;

    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] val;
    } sextet_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       has_byte;
        logic [1:0] status;
        logic       run_last;
        logic       stream_end;
    } result_t;

    typedef struct packed {
        logic [1:0]  quad_phase;
        logic [17:0] held_sextets;
        logic [2:0]  pad_run;
        logic        error_seen;
    } dec_state_t;

    typedef struct packed {
        logic [1:0] n;
        result_t [MAX_RES-1:0] res;
    } dec_out_t;

    localparam result_t RES_NONE = '0;

    // Base64 alphabet: A-Z, a-z, 0-9, '+', '/'; '=' is padding.
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t    s;
        logic [7:0] d;
        s = '0;
        d = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            d = 8'd62;
        end else if (c == 8'h2F) begin
            d = 8'd63;
        end else if (c == 8'h3D) begin
            s.pad = 1'b1;
        end else begin
            s.bad = 1'b1;
        end
        s.val = d[5:0];
        return s;
    endfunction

endpackage

[sv/b64d_char_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_char_if
// Request channel carrying one encoded character.
// ----------------------------------------------------------------------------
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       stream_last;

    modport source (output valid, output char_in, output stream_last, input ready);
    modport sink   (input valid, input char_in, input stream_last, output ready);
endinterface

[sv/b64d_byte_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_byte_if
// Request channel carrying one decoded result.
// ----------------------------------------------------------------------------
interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       has_byte;
    logic [1:0] status;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output byte_out, output has_byte, output status,
                    output run_last, output stream_end, input ready);
    modport sink   (input valid, input byte_out, input has_byte, input status,
                    input run_last, input stream_end, output ready);
endinterface

[sv/b64d_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_decode
// Per-character decode: next quad state and up to three results.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic [7:0]          char_in,
    input  logic                stream_last,
    input  b64d_pkg::dec_state_t st,
    output b64d_pkg::dec_state_t st_next,
    output b64d_pkg::dec_out_t   dout
);

    b64d_pkg::sextet_t s;
    logic [5:0]  sv;
    logic [2:0]  pad_n;
    logic [23:0] word;
    logic [1:0]  cnt;
    logic [7:0]  bytes [3];

    assign s     = b64d_pkg::sextet_of(char_in);
    assign sv    = s.pad ? 6'd0 : s.val;
    assign pad_n = s.pad ? ((st.pad_run < b64d_pkg::PAD_SAT) ? st.pad_run + 3'd1 : st.pad_run)
                         : 3'd0;
    assign word  = {st.held_sextets, sv};
    assign cnt   = 2'd3 - pad_n[1:0];
    assign bytes[0] = word[23:16];
    assign bytes[1] = word[15:8];
    assign bytes[2] = word[7:0];

    always_comb begin
        st_next = st;
        dout    = '0;
        for (int k = 0; k < 3; k++) begin
            dout.res[k] = b64d_pkg::RES_NONE;
        end

        if (st.error_seen) begin
            if (stream_last) begin
                dout.n               = 2'd1;
                dout.res[0].status   = b64d_pkg::ST_OK;
                dout.res[0].run_last = 1'b1;
                dout.res[0].stream_end = 1'b1;
                st_next              = '0;
            end
        end else if (s.bad) begin
            dout.n                 = 2'd1;
            dout.res[0].status     = b64d_pkg::ST_BAD_CHAR;
            dout.res[0].run_last   = 1'b1;
            dout.res[0].stream_end = stream_last;
            if (stream_last) begin
                st_next = '0;
            end else begin
                st_next.error_seen = 1'b1;
            end
        end else if (st.quad_phase != 2'd3) begin
            st_next.pad_run      = pad_n;
            st_next.held_sextets = {st.held_sextets[11:0], sv};
            st_next.quad_phase   = st.quad_phase + 2'd1;
            if (stream_last) begin
                dout.n                 = 2'd1;
                dout.res[0].status     = b64d_pkg::ST_BAD_LEN;
                dout.res[0].run_last   = 1'b1;
                dout.res[0].stream_end = 1'b1;
                st_next                = '0;
            end
        end else if (stream_last && pad_n >= b64d_pkg::PAD_SAT) begin
            // trailing '=' run reaches into bytes already sent
            dout.n                 = 2'd1;
            dout.res[0].status     = b64d_pkg::ST_PAD_OVERRUN;
            dout.res[0].run_last   = 1'b1;
            dout.res[0].stream_end = 1'b1;
            st_next                = '0;
        end else if (stream_last && cnt == 2'd0) begin
            dout.n                 = 2'd1;
            dout.res[0].status     = b64d_pkg::ST_OK;
            dout.res[0].run_last   = 1'b1;
            dout.res[0].stream_end = 1'b1;
            st_next                = '0;
        end else begin
            dout.n = stream_last ? cnt : 2'd3;
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < dout.n) begin
                    dout.res[k].byte_out   = bytes[k];
                    dout.res[k].has_byte   = 1'b1;
                    dout.res[k].status     = b64d_pkg::ST_OK;
                    dout.res[k].run_last   = (2'(k + 1) == dout.n);
                    dout.res[k].stream_end = (2'(k + 1) == dout.n) && stream_last;
                end
            end
            if (stream_last) begin
                st_next = '0;
            end else begin
                st_next.quad_phase   = 2'd0;
                st_next.held_sextets = '0;
                st_next.pad_run      = pad_n;
            end
        end
    end

endmodule

[sv/base64_stream_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder, one character per request, up to three results.
// ----------------------------------------------------------------------------
// Usage:
//  - chars: one character per request, stream_last on the final character.
//  - bytes: results in order. has_byte flags a data byte; status reports
//    invalid character, bad length or padding overrun; run_last closes the
//    results of one character, stream_end closes the stream.
//  - A character goes into the input register, is decoded from it and, once
//    the queue has room, written into the result queue; its results are then
//    offered in order from the queue head.
//  - Throughput: one character per cycle with room in the queue. The queue
//    drains one result per cycle, the fourth character of a quad pushes three,
//    so a sustained stream of one character per cycle keeps up (three per four).
//  - A character leaves the input register only when the queue has room for
//    three results; when the receiver stalls, the queue fills and chars.ready
//    drops. No request is lost.
//  - Reset clears the quad state, error flag and queue. The last character
//    of a stream always returns the decoder to its reset state.
//  - FIFO_DEPTH: result queue depth, a power of two, at least 4.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
    parameter int unsigned FIFO_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    b64d_char_if.sink     chars,
    b64d_byte_if.source   bytes
);

    localparam int unsigned PW = $clog2(FIFO_DEPTH);
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(FIFO_DEPTH - 3);

    // input register
    logic       s_vld_reg, s_vld_next;
    logic [7:0] s_char_reg;
    logic       s_last_reg;
    logic       s_go;

    // decoder state
    b64d_pkg::dec_state_t st_reg, st_next;
    b64d_pkg::dec_out_t   dec;

    // result queue
    b64d_pkg::result_t q_mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    push_n;
    logic          pop;
    b64d_pkg::result_t head;

    // stage moves on only with room for a full quad's output
    assign s_go        = s_vld_reg && (cnt_reg <= ROOM_LIMIT);
    assign chars.ready = !s_vld_reg || s_go;
    assign s_vld_next  = (chars.valid && chars.ready) || (s_vld_reg && !s_go);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_vld_reg <= 1'b0;
        end else begin
            s_vld_reg <= s_vld_next;
        end
    end

    always_ff @(posedge clk) begin
        if (chars.valid && chars.ready) begin
            s_char_reg <= chars.char_in;
            s_last_reg <= chars.stream_last;
        end
    end

    b64d_decode u_dec (
        .char_in     (s_char_reg),
        .stream_last (s_last_reg),
        .st          (st_reg),
        .st_next     (st_next),
        .dout        (dec)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg <= '0;
        end else if (s_go) begin
            st_reg <= st_next;
        end
    end

    // queue bookkeeping
    assign push_n    = s_go ? dec.n : 2'd0;
    assign pop       = bytes.valid && bytes.ready;
    assign wptr_next = wptr_reg + PW'(push_n);
    assign rptr_next = rptr_reg + PW'(pop);
    assign cnt_next  = cnt_reg + CW'(push_n) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push_n) begin
                q_mem_reg[wptr_reg + PW'(k)] <= dec.res[k];
            end
        end
    end

    assign head             = q_mem_reg[rptr_reg];
    assign bytes.valid      = (cnt_reg != '0);
    assign bytes.byte_out   = head.byte_out;
    assign bytes.has_byte   = head.has_byte;
    assign bytes.status     = head.status;
    assign bytes.run_last   = head.run_last;
    assign bytes.stream_end = head.stream_end;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FIFO_DEPTH))
        else $error("result queue count above depth");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> (s_vld_reg && cnt_reg > ROOM_LIMIT))
        else $error("input stalled without a full queue");

    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_go && s_last_reg) |-> (dec.n != 2'd0))
        else $error("last character produced no result");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_go && s_last_reg) |=> (st_reg == '0))
        else $error("state not cleared after last character");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg == $past(cnt_reg) + CW'($past(push_n)) - CW'($past(pop))))
        else $error("queue count out of step");

endmodule

[dv/tb_base64_stream_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_top
// Self-checking bench for the streaming base64 decoder. A queue of character
// requests (directed cases, then random streams, mostly well formed) feeds a
// clocked driver; an in-bench decoder predicts every result at acceptance and
// a clocked monitor checks the result channel against it in order. Both
// sides idle in random bursts, the receiver also holds off once for a long
// stretch so the result queue fills and the character channel backs up.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_top;

    localparam int          ITEMS      = 320;
    localparam int          CALM_TAIL  = 40;    // last requests sent with no idling
    localparam int          HOLD_AT    = 100;   // requests accepted before the long hold
    localparam int          HOLD_LEN   = 120;   // cycles the receiver holds off
    localparam int          DRAIN_WAIT = 20;
    localparam logic [7:0]  PAD_CHAR   = "=";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    logic clk = 1'b0;
    logic rst_n;

    b64d_char_if char_ch ();
    b64d_byte_if byte_ch ();

    base64_stream_decoder_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (char_ch),
        .bytes (byte_ch)
    );

    // Pending character requests, filled up front by the stimulus block.
    char_req_t           char_q[$];
    // Results the decoder owes, oldest first.
    b64d_pkg::result_t   owed_q[$];

    // Bench copy of the decoder state.
    logic [1:0]  quad_pos;
    logic [17:0] quad_bits;
    logic [2:0]  pad_len;
    logic        in_error;

    int          chars_sent;     // accepted requests, updated with NBAs
    int          calm_mark;
    int          total_chars;
    int          mismatches     = 0;
    int          results_seen   = 0;
    int          bytes_seen     = 0;
    int          streams_seen   = 0;
    int          status_hits[4] = '{0, 0, 0, 0};

    logic        long_hold;
    logic        hold_done;
    int          hold_left;
    int          src_gap;
    int          snk_gap;

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------------
    task automatic owe_result(input logic [7:0] b, input logic has,
                              input b64d_pkg::status_t st, input logic rl,
                              input logic se);
        b64d_pkg::result_t r;
        r.byte_out   = b;
        r.has_byte   = has;
        r.status     = st;
        r.run_last   = rl;
        r.stream_end = se;
        owed_q.push_back(r);
    endtask

    task automatic clear_decoder();
        quad_pos  = '0;
        quad_bits = '0;
        pad_len   = '0;
        in_error  = 1'b0;
    endtask

    // Works out what one accepted character makes the decoder emit.
    task automatic decode_char(input logic [7:0] ch, input logic fin);
        logic [5:0]  sv;
        logic [7:0]  d;
        logic        bad;
        logic        pad;
        logic [23:0] word;
        int          nbytes;
        bad = 1'b0;
        pad = 1'b0;
        d   = '0;
        if (ch >= "A" && ch <= "Z")
            d = ch - 8'h41;
        else if (ch >= "a" && ch <= "z")
            d = ch - 8'h61 + 8'd26;
        else if (ch >= "0" && ch <= "9")
            d = ch - 8'h30 + 8'd52;
        else if (ch == "+")
            d = 8'd62;
        else if (ch == "/")
            d = 8'd63;
        else if (ch == PAD_CHAR)
            pad = 1'b1;
        else
            bad = 1'b1;
        sv = d[5:0];

        // After an error only the stream's last character has an effect.
        if (in_error) begin
            if (fin) begin
                owe_result('0, 1'b0, b64d_pkg::ST_OK, 1'b1, 1'b1);
                clear_decoder();
            end
            return;
        end
        if (bad) begin
            owe_result('0, 1'b0, b64d_pkg::ST_BAD_CHAR, 1'b1, fin);
            if (fin)
                clear_decoder();
            else
                in_error = 1'b1;
            return;
        end

        // '=' decodes as zero and extends the trailing pad run.
        if (pad) begin
            if (pad_len < b64d_pkg::PAD_SAT)
                pad_len = pad_len + 3'd1;
        end else begin
            pad_len = '0;
        end

        if (quad_pos < 2'd3) begin
            quad_bits = {quad_bits[11:0], sv};
            quad_pos  = quad_pos + 2'd1;
            if (fin) begin
                owe_result('0, 1'b0, b64d_pkg::ST_BAD_LEN, 1'b1, 1'b1);
                clear_decoder();
            end
            return;
        end

        word   = {quad_bits, sv};
        nbytes = 3;
        if (fin) begin
            if (pad_len >= b64d_pkg::PAD_SAT) begin
                owe_result('0, 1'b0, b64d_pkg::ST_PAD_OVERRUN, 1'b1, 1'b1);
                clear_decoder();
                return;
            end
            nbytes = 3 - int'(pad_len);
            if (nbytes == 0) begin
                owe_result('0, 1'b0, b64d_pkg::ST_OK, 1'b1, 1'b1);
                clear_decoder();
                return;
            end
        end
        for (int i = 0; i < nbytes; i++)
            owe_result(word[23 - 8*i -: 8], 1'b1, b64d_pkg::ST_OK, i == nbytes - 1,
                       (i == nbytes - 1) && fin);
        if (fin) begin
            clear_decoder();
        end else begin
            quad_pos  = '0;
            quad_bits = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] alpha_char(input int unsigned idx);
        if (idx < 26)
            return 8'("A" + idx);
        if (idx < 52)
            return 8'("a" + (idx - 26));
        if (idx < 62)
            return 8'("0" + (idx - 52));
        return (idx == 62) ? "+" : "/";
    endfunction

    task automatic queue_char(input logic [7:0] ch, input logic last);
        char_req_t r;
        r.ch   = ch;
        r.last = last;
        char_q.push_back(r);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], i == s.len() - 1);
    endtask

    // ------------------------------------------------------------------------
    // Character driver: one request per handshake, random idle bursts
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : char_driver
        logic      busy;
        char_req_t req;
        if (!rst_n) begin
            char_ch.valid       <= 1'b0;
            char_ch.char_in     <= '0;
            char_ch.stream_last <= 1'b0;
            src_gap             <= 0;
            chars_sent          <= 0;
            clear_decoder();
        end else begin
            busy = char_ch.valid;
            if (char_ch.valid && char_ch.ready) begin
                decode_char(char_ch.char_in, char_ch.stream_last);
                chars_sent <= chars_sent + 1;
                busy = 1'b0;
            end
            if (!busy) begin
                if (src_gap > 0) begin
                    src_gap       <= src_gap - 1;
                    char_ch.valid <= 1'b0;
                end else if (char_q.size() == 0) begin
                    char_ch.valid <= 1'b0;
                end else if (!long_hold && chars_sent < calm_mark
                             && $urandom_range(0, 9) == 0) begin
                    // idle now, then for a random gap drawn into src_gap
                    src_gap       <= $urandom_range(0, 16);
                    char_ch.valid <= 1'b0;
                end else begin
                    req = char_q.pop_front();
                    char_ch.valid       <= 1'b1;
                    char_ch.char_in     <= req.ch;
                    char_ch.stream_last <= req.last;
                end
            end
        end
    end

    // Long receiver hold, counted here; the sender keeps offering meanwhile.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            long_hold <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end else if (!hold_done && chars_sent >= HOLD_AT) begin
            long_hold <= 1'b1;
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                long_hold <= 1'b0;
        end
    end

    // Result receiver: ready with random stall bursts.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            byte_ch.ready <= 1'b0;
            snk_gap       <= 0;
        end else if (long_hold) begin
            byte_ch.ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap       <= snk_gap - 1;
            byte_ch.ready <= 1'b0;
        end else if (chars_sent < calm_mark && $urandom_range(0, 7) == 0) begin
            snk_gap       <= $urandom_range(0, 16);
            byte_ch.ready <= 1'b0;
        end else begin
            byte_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    function automatic void report_bad(input string why, input b64d_pkg::result_t want,
                                       input b64d_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ERROR %s: want byte=%02h has=%0d st=%0d rl=%0d end=%0d,",
                     $realtime, why, want.byte_out, want.has_byte, want.status,
                     want.run_last, want.stream_end,
                     " got byte=%02h has=%0d st=%0d rl=%0d end=%0d",
                     got.byte_out, got.has_byte, got.status, got.run_last,
                     got.stream_end);
    endfunction

    always @(posedge clk) begin : result_monitor
        b64d_pkg::result_t got;
        b64d_pkg::result_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready) begin
            got.byte_out   = byte_ch.byte_out;
            got.has_byte   = byte_ch.has_byte;
            got.status     = byte_ch.status;
            got.run_last   = byte_ch.run_last;
            got.stream_end = byte_ch.stream_end;
            results_seen++;
            if (got.has_byte === 1'b1)
                bytes_seen++;
            if (got.stream_end === 1'b1)
                streams_seen++;
            if (!$isunknown(got.status))
                status_hits[got.status]++;
            if (owed_q.size() == 0) begin
                report_bad("unexpected result", b64d_pkg::RES_NONE, got);
            end else begin
                want = owed_q.pop_front();
                if (got.byte_out !== want.byte_out || got.has_byte !== want.has_byte
                    || got.status !== want.status || got.run_last !== want.run_last
                    || got.stream_end !== want.stream_end)
                    report_bad("result mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        int nq;
        int pads;
        int len;
        int npad;
        int n;
        int missing;
        logic fin;

        rst_n     = 1'b0;
        calm_mark = 0;

        // Directed: embedded pad plus a one-pad final quad, two and three
        // trailing pads, overrun, short stream, errors mid-stream and at end.
        queue_text("/=90+AA=");
        queue_text("Zz==");
        queue_text("a===");
        queue_text("====");
        queue_text("Q");
        queue_char(8'h00, 1'b0);    // bad char, sets the sticky error
        queue_char(8'hFF, 1'b0);    // ignored while in error
        queue_char("A", 1'b1);      // closes the errored stream
        queue_char(8'hFF, 1'b1);    // bad char that is also the last

        while (char_q.size() < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                // mostly well-formed stream, short, random content
                nq   = $urandom_range(1, 4);
                pads = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
                n    = 4 * nq;
                for (int k = 0; k < n; k++) begin
                    fin = (k == n - 1);
                    if (k >= n - pads)
                        queue_char(PAD_CHAR, fin);
                    else if (k < n - 4 && $urandom_range(0, 19) == 0)
                        queue_char(PAD_CHAR, fin);
                    else if ($urandom_range(0, 39) == 0)
                        queue_char(8'($urandom_range(0, 255)), fin);
                    else
                        queue_char(alpha_char($urandom_range(0, 63)), fin);
                end
            end else if (pick < 78) begin
                // length not a multiple of four
                len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    queue_char(($urandom_range(0, 9) == 0) ? PAD_CHAR
                               : alpha_char($urandom_range(0, 63)), k == len - 1);
            end else if (pick < 88) begin
                // trailing pad run past the final quad
                len  = 4 * $urandom_range(1, 3);
                npad = $urandom_range(4, len);
                for (int k = 0; k < len; k++)
                    queue_char((k >= len - npad) ? PAD_CHAR
                               : alpha_char($urandom_range(0, 63)), k == len - 1);
            end else begin
                // noise: any byte value
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    queue_char(8'($urandom_range(0, 255)), k == len - 1);
            end
        end
        total_chars = char_q.size();
        calm_mark   = total_chars - CALM_TAIL;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_sent < total_chars || owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        missing = owed_q.size();
        if (missing != 0)
            $display("%0d expected results never arrived", missing);

        $display("Decoded %0d characters in %0d streams: %0d results, %0d data bytes",
                 total_chars, streams_seen, results_seen, bytes_seen);
        $display("Status seen: ok %0d, bad char %0d, bad length %0d, pad overrun %0d;",
                 status_hits[b64d_pkg::ST_OK], status_hits[b64d_pkg::ST_BAD_CHAR],
                 status_hits[b64d_pkg::ST_BAD_LEN], status_hits[b64d_pkg::ST_PAD_OVERRUN],
                 " %0d mismatches", mismatches);
        if (mismatches == 0 && missing == 0)
            $display("tb_base64_stream_decoder_top passed");
        else
            $display("tb_base64_stream_decoder_top failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("Timeout: %0d of %0d characters accepted, %0d results owed",
                 chars_sent, total_chars, owed_q.size());
        $display("tb_base64_stream_decoder_top failed");
        $finish;
    end

endmodule
